// ----- hw/rtl/stcrs_pkg.sv -----
// Package for the counting segment tree block.
// Holds result and operation codes and the controller/datapath interface structs.
// No dependencies.
package stcrs_pkg;

    // Operation codes of an input beat.
    localparam logic OP_INCREMENT = 1'b0;
    localparam logic OP_QUERY     = 1'b1;

    // Status codes of a result beat.
    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_ANSWER  = 2'd1;
    localparam logic [1:0] STATUS_IGNORED = 2'd2;

    // Domain size register.
    localparam int          DOMAIN_W     = 11;
    localparam logic [10:0] DOMAIN_RESET = 11'd1024;

    // Fixed payload widths.
    localparam int POS_W = 10;
    localparam int SUM_W = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture an input beat
        logic clear;      // write zero at the sweep address
        logic rd_leaf;    // read the leaf node of the increment
        logic inc_step;   // write one node on the update path
        logic inc_first;  // the node written is the leaf itself
        logic q_left;     // left-bound step of the range walk
        logic q_right;    // right-bound step of the range walk
        logic emit;       // move the result to the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_query;
        logic inc_ok;
        logic q_empty;
        logic l_lt_r;
        logic k_root;
        logic clr_last;
    } t_sts;

endpackage

// ----- hw/rtl/stcrs_dpath.sv -----
// Datapath of the counting segment tree: node memory, walk registers, result registers.
// Depends on stcrs_pkg; driven by stcrs_ctrl through t_cmd and t_sts.
module stcrs_dpath #(
    parameter int POSITIONS  = 1024,
    parameter int NODE_STORE = 2048
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [stcrs_pkg::DOMAIN_W-1:0]   i_cfg_wdata,
    input  logic                             i_operation,
    input  logic [stcrs_pkg::POS_W-1:0]      i_position,
    input  logic [stcrs_pkg::POS_W-1:0]      i_range_low,
    input  logic [stcrs_pkg::POS_W-1:0]      i_range_high,
    input  stcrs_pkg::t_cmd                  i_cmd,
    output stcrs_pkg::t_sts                  o_sts,
    output logic [1:0]                       o_status,
    output logic [stcrs_pkg::SUM_W-1:0]      o_range_sum
);

    localparam int IW = $clog2(2 * POSITIONS + 1);
    localparam int AW = $clog2(NODE_STORE);
    localparam int WW = ((IW > AW) ? IW : AW) + 1;
    localparam int CW = ((IW > stcrs_pkg::DOMAIN_W) ? IW : stcrs_pkg::DOMAIN_W) + 1;
    localparam int SW = stcrs_pkg::SUM_W;

    function automatic logic f_in_range(input logic [IW-1:0] k);
        f_in_range = WW'(k) < WW'(NODE_STORE);
    endfunction

    function automatic logic [AW-1:0] f_addr(input logic [IW-1:0] k);
        logic [WW-1:0] kx;
        kx = WW'(k);
        f_addr = f_in_range(k) ? kx[AW-1:0] : '0;
    endfunction

    function automatic logic [SW-1:0] f_sat_add(input logic [SW-1:0] a,
                                                input logic [SW-1:0] b);
        logic [SW:0] s;
        s = {1'b0, a} + {1'b0, b};
        f_sat_add = s[SW] ? '1 : s[SW-1:0];
    endfunction

    logic [SW-1:0] r_mem [NODE_STORE];
    logic [SW-1:0] r_rdata;
    logic          r_rd_ok;

    logic [stcrs_pkg::DOMAIN_W-1:0] r_domain;
    logic [AW-1:0] r_clr;
    logic [IW-1:0] r_k, r_l, r_r;
    logic [SW-1:0] r_acc, r_sum;
    logic          r_pend;
    logic          r_op, r_inc_ok, r_q_empty;
    logic [1:0]    r_status;
    logic [1:0]    r_out_status;
    logic [SW-1:0] r_out_sum;

    logic [CW-1:0] dom_c, hi_c, lo_c, pos_c;
    logic          n_inc_ok, n_q_empty;
    logic [CW-1:0] l_c, r_c, k_c;
    logic [SW-1:0] rd_m, inc_val, acc_sum;
    logic [IW-1:0] rd_idx;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [SW-1:0] wr_data;
    logic          k_ok;

    // Decode of the incoming beat against the effective domain.
    always_comb begin
        dom_c = (CW'(r_domain) > CW'(POSITIONS)) ? CW'(POSITIONS) : CW'(r_domain);
        pos_c = CW'(i_position);
        lo_c  = CW'(i_range_low);
        hi_c  = (CW'(i_range_high) > dom_c - CW'(1)) ? dom_c - CW'(1) : CW'(i_range_high);
        n_inc_ok  = pos_c < dom_c;
        n_q_empty = (dom_c == '0) || (lo_c > hi_c);
        l_c = lo_c + CW'(POSITIONS);
        r_c = hi_c + CW'(POSITIONS) + CW'(1);
        k_c = pos_c + CW'(POSITIONS);
    end

    assign rd_m    = r_rd_ok ? r_rdata : '0;
    assign inc_val = i_cmd.inc_first ? f_sat_add(rd_m, SW'(1)) : f_sat_add(r_acc, rd_m);
    assign acc_sum = f_sat_add(r_sum, rd_m);
    assign k_ok    = f_in_range(r_k);

    // Read address for the next cycle.
    always_comb begin
        priority if (i_cmd.inc_step) begin
            rd_idx = r_k ^ IW'(1);
        end else if (i_cmd.q_left) begin
            rd_idx = r_l;
        end else if (i_cmd.q_right) begin
            rd_idx = r_r - IW'(1);
        end else if (i_cmd.rd_leaf) begin
            rd_idx = r_k;
        end else begin
            rd_idx = r_k;
        end
    end

    always_comb begin
        wr_en   = i_cmd.clear || (i_cmd.inc_step && k_ok);
        wr_addr = i_cmd.clear ? r_clr : f_addr(r_k);
        wr_data = i_cmd.clear ? '0 : inc_val;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[f_addr(rd_idx)];
        r_rd_ok <= f_in_range(rd_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_domain <= stcrs_pkg::DOMAIN_RESET;
            r_clr    <= '0;
            r_pend   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_domain <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.load) begin
                r_pend <= 1'b0;
            end else if (i_cmd.q_left) begin
                r_pend <= (r_l < r_r) && r_l[0];
            end else if (i_cmd.q_right) begin
                r_pend <= r_r[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_inc_ok  <= n_inc_ok;
            r_q_empty <= n_q_empty;
            r_l       <= l_c[IW-1:0];
            r_r       <= r_c[IW-1:0];
            r_k       <= k_c[IW-1:0];
            r_sum     <= '0;
            if (i_operation == stcrs_pkg::OP_QUERY) begin
                r_status <= stcrs_pkg::STATUS_ANSWER;
            end else if (n_inc_ok) begin
                r_status <= stcrs_pkg::STATUS_DONE;
            end else begin
                r_status <= stcrs_pkg::STATUS_IGNORED;
            end
        end
        if (i_cmd.inc_step) begin
            // A node beyond the store keeps reading as zero.
            r_acc <= k_ok ? inc_val : '0;
            r_k   <= r_k >> 1;
        end
        if ((i_cmd.q_left || i_cmd.q_right) && r_pend) begin
            r_sum <= acc_sum;
        end
        if (i_cmd.q_left && (r_l < r_r) && r_l[0]) begin
            r_l <= r_l + IW'(1);
        end
        if (i_cmd.q_right) begin
            r_l <= r_l >> 1;
            r_r <= r_r >> 1;
        end
        if (i_cmd.emit) begin
            r_out_status <= r_status;
            r_out_sum    <= r_sum;
        end
    end

    always_comb begin
        o_sts.op_query = (r_op == stcrs_pkg::OP_QUERY);
        o_sts.inc_ok   = r_inc_ok;
        o_sts.q_empty  = r_q_empty;
        o_sts.l_lt_r   = r_l < r_r;
        o_sts.k_root   = (r_k == IW'(1));
        o_sts.clr_last = (r_clr == AW'(NODE_STORE - 1));
    end

    assign o_status    = r_out_status;
    assign o_range_sum = r_out_sum;

endmodule

// ----- hw/rtl/stcrs_ctrl.sv -----
// Controller of the counting segment tree: sequences the clearing sweep,
// the update walk and the range walk. Depends on stcrs_pkg.
module stcrs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_stall,
    output logic            o_valid,
    input  stcrs_pkg::t_sts i_sts,
    output stcrs_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_LEAF   = 3'd3;
    localparam logic [2:0] S_INC    = 3'd4;
    localparam logic [2:0] S_QL     = 3'd5;
    localparam logic [2:0] S_QR     = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_sts.op_query) begin
                    if (i_sts.inc_ok) begin
                        o_cmd.rd_leaf = 1'b1;
                        n_state       = S_LEAF;
                    end else begin
                        n_state = S_FIN;
                    end
                end else if (i_sts.q_empty) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_QL;
                end
            end
            S_LEAF, S_INC: begin
                o_cmd.inc_step  = 1'b1;
                o_cmd.inc_first = (r_state == S_LEAF);
                n_state         = i_sts.k_root ? S_FIN : S_INC;
            end
            S_QL: begin
                o_cmd.q_left = 1'b1;
                n_state      = i_sts.l_lt_r ? S_QR : S_FIN;
            end
            S_QR: begin
                o_cmd.q_right = 1'b1;
                n_state       = S_QL;
            end
            S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ----- hw/rtl/segment_tree_count_range_sum.sv -----
// Counting segment tree with point increment and inclusive range-sum query.
// Top level; instantiates stcrs_ctrl and stcrs_dpath, uses stcrs_pkg.
//
// The block keeps one saturating 32-bit count per position in a binary tree held in
// a node memory with one read port and one write port: leaf p is node POSITIONS + p
// and each inner node holds the saturated sum of its two children. Every input beat
// gives exactly one result beat. An increment returns status 0 (done) or 2 (position
// at or beyond the configured domain, nothing changed), with a zero sum. A query
// returns status 1 and the saturated sum over range_low..range_high, with the upper
// bound clipped to the domain; an empty range answers zero. After reset the block
// clears the node memory one entry per cycle and holds o_stall high until the sweep
// is done; the domain register can be written meanwhile. An increment then reads the
// leaf, then writes one node per tree level, each write overlapped with the read of
// the next sibling. A query alternates a left-bound step and a right-bound step for
// each level of the range walk, which climbs at most log2(POSITIONS) + 1 levels.
// One item is worked on at a time, but a finished result waits in an output
// register, so the next beat is accepted while the previous result is still stalled
// downstream. The domain register may be written only while no beat is in flight.
module segment_tree_count_range_sum #(
    parameter int POSITIONS  = 1024,
    parameter int NODE_STORE = 2048
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration: domain size.
    input  logic                            i_cfg_we,
    input  logic [stcrs_pkg::DOMAIN_W-1:0]  i_cfg_wdata,
    // Input channel.
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_operation,
    input  logic [stcrs_pkg::POS_W-1:0]     i_position,
    input  logic [stcrs_pkg::POS_W-1:0]     i_range_low,
    input  logic [stcrs_pkg::POS_W-1:0]     i_range_high,
    // Result channel.
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [1:0]                      o_status,
    output logic [stcrs_pkg::SUM_W-1:0]     o_range_sum
);

    // Commands and status between the sequencer and the datapath.
    stcrs_pkg::t_cmd cmd;
    stcrs_pkg::t_sts sts;

    stcrs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    stcrs_dpath #(
        .POSITIONS  (POSITIONS),
        .NODE_STORE (NODE_STORE)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_operation  (i_operation),
        .i_position   (i_position),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_status     (o_status),
        .o_range_sum  (o_range_sum)
    );

endmodule

// ----- hw/rtl/stcrs_chk.sv -----
// Port-level checker for the counting segment tree, bound to the top level.
// Depends on stcrs_pkg and segment_tree_count_range_sum.
module stcrs_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [1:0]                  o_status,
    input logic [stcrs_pkg::SUM_W-1:0] o_range_sum
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_range_sum))
        else $error("result beat changed while stalled");

    // Only a query answer carries a sum.
    a_inc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != stcrs_pkg::STATUS_ANSWER) |-> o_range_sum == '0)
        else $error("increment result carries a nonzero sum");

    // An accepted beat keeps the input stalled while it is worked on.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after an accepted beat");

    // A new result appears only at the end of a busy period.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared while the block was idle");

endmodule

bind segment_tree_count_range_sum stcrs_chk u_stcrs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_status    (o_status),
    .o_range_sum (o_range_sum)
);
